// ----- rtl/b2da_pkg.sv -----
package b2da_pkg;

    localparam int unsigned BinWidth   = 32;
    localparam int unsigned NumDigits  = 10;
    localparam int unsigned DigitWidth = 4;
    localparam int unsigned CharWidth  = 6;
    localparam int unsigned CntWidth   = 5;

    localparam logic [CntWidth-1:0]   LastShift = CntWidth'(BinWidth - 1);
    localparam logic [CntWidth-1:0]   LastDigit = CntWidth'(NumDigits - 1);
    localparam logic [CharWidth-1:0]  CharZero  = CharWidth'(48);
    localparam logic [DigitWidth-1:0] AdjLimit  = DigitWidth'(5);
    localparam logic [DigitWidth-1:0] AdjAdd    = DigitWidth'(3);
    localparam logic [DigitWidth-1:0] MaxDigit  = DigitWidth'(9);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SHIFT,
        ST_EMIT
    } state_t;

    // Per-cycle command shared by every cell in the row
    typedef struct packed {
        logic clear;
        logic shift_bin;
        logic shift_dig;
    } cell_ctrl_t;

endpackage

// ----- rtl/binary_to_decimal_ascii_core.sv -----
// Binary to decimal ASCII converter.
// Command channel: raise start with a 32-bit value; the word is taken at the
// clock edge where start is high and busy is low. busy stays high until the
// last digit of that number has been sent.
// Result channel: each decimal digit leaves as one word on digit_char (ASCII
// '0'..'9'), most significant first, with no leading zeros, marked by strobe
// for exactly one cycle. last_digit is high on the final digit. Zero gives a
// single '0'. The receiver cannot stall; it must take every strobed word.
// Timing: a row of ten BCD cells runs the shift-and-add-3 conversion, one
// input bit per cycle. The row then shifts its digits toward the output,
// one per cycle, with leading zeros dropped silently. A new word is only
// accepted once the last digit of the current number has been sent.
// Reset clears the controller and all cells at once; nothing is pending
// after reset and busy is low.
module binary_to_decimal_ascii_core (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [b2da_pkg::BinWidth-1:0]  value,
    output logic                           strobe,
    output logic [b2da_pkg::CharWidth-1:0] digit_char,
    output logic                           last_digit
);
    import b2da_pkg::*;

    state_t                state_reg;
    state_t                state_next;
    logic [CntWidth-1:0]   cnt_reg;
    logic [CntWidth-1:0]   cnt_next;
    logic                  started_reg;
    logic                  started_next;
    logic [BinWidth-1:0]   bin_reg;
    logic [BinWidth-1:0]   bin_next;

    cell_ctrl_t            ctrl;
    logic                  accept;
    logic [NumDigits:0]    bit_chain;
    logic [DigitWidth-1:0] dig_chain [NumDigits+1];
    logic [DigitWidth-1:0] top_digit;
    logic                  at_last;

    assign accept    = start && (state_reg == ST_IDLE);
    assign top_digit = dig_chain[NumDigits];
    assign at_last   = (cnt_reg == LastDigit);

    // Binary bits enter at the low cell, MSB of the operand first
    assign bit_chain[0] = bin_reg[BinWidth-1];
    // Empty digits fill in behind the row as it drains
    assign dig_chain[0] = '0;

    for (genvar i = 0; i < NumDigits; i++)
    begin : g_cell
        b2da_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .ctrl    (ctrl),
            .bit_in  (bit_chain[i]),
            .dig_in  (dig_chain[i]),
            .bit_out (bit_chain[i+1]),
            .digit   (dig_chain[i+1])
        );
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_SHIFT;
                end
            end
            ST_SHIFT:
            begin
                if (cnt_reg == LastShift)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (at_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs and datapath control
    always_comb
    begin
        ctrl         = '0;
        busy         = 1'b1;
        strobe       = 1'b0;
        last_digit   = 1'b0;
        cnt_next     = cnt_reg;
        started_next = started_reg;
        bin_next     = bin_reg;
        case (state_reg)
            ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    ctrl.clear   = 1'b1;
                    cnt_next     = '0;
                    started_next = 1'b0;
                    bin_next     = value;
                end
            end
            ST_SHIFT:
            begin
                ctrl.shift_bin = 1'b1;
                bin_next       = {bin_reg[BinWidth-2:0], 1'b0};
                cnt_next       = (cnt_reg == LastShift) ? '0 : cnt_reg + 1'b1;
            end
            ST_EMIT:
            begin
                // Drop leading zeros, but always send the units digit
                ctrl.shift_dig = 1'b1;
                strobe         = started_reg || at_last || (top_digit != '0);
                last_digit     = at_last;
                started_next   = started_reg || strobe;
                cnt_next       = at_last ? '0 : cnt_reg + 1'b1;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

    assign digit_char = CharZero | CharWidth'(top_digit);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            started_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            started_reg <= started_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bin_reg <= bin_next;
    end

    // A 32-bit value fits ten digits: nothing may spill out of the top cell
    a_no_spill: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SHIFT) |-> !bit_chain[NumDigits])
        else $error("BCD row overflowed during conversion");

    a_digit_range: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> (top_digit <= MaxDigit))
        else $error("emitted digit out of decimal range");

    a_units_sent: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT && at_last) |-> (strobe && last_digit))
        else $error("units digit not emitted as last word");

    a_accept_clears: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == ST_SHIFT && cnt_reg == '0 && !started_reg))
        else $error("conversion did not start cleanly");

    a_no_digit_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && last_digit) |=> (state_reg == ST_IDLE && !strobe))
        else $error("word emitted after last digit");

endmodule

// ----- rtl/b2da_cell.sv -----
module b2da_cell (
    input  logic                            clk,
    input  logic                            rst_n,
    input  b2da_pkg::cell_ctrl_t            ctrl,
    input  logic                            bit_in,
    input  logic [b2da_pkg::DigitWidth-1:0] dig_in,
    output logic                            bit_out,
    output logic [b2da_pkg::DigitWidth-1:0] digit
);
    import b2da_pkg::*;

    logic [DigitWidth-1:0] digit_reg;
    logic [DigitWidth-1:0] digit_next;
    logic [DigitWidth-1:0] adj;

    // Add-3 correction before the doubling step
    assign adj     = (digit_reg >= AdjLimit) ? (digit_reg + AdjAdd) : digit_reg;
    assign bit_out = adj[DigitWidth-1];
    assign digit   = digit_reg;

    always_comb
    begin
        digit_next = digit_reg;
        if (ctrl.clear)
        begin
            digit_next = '0;
        end
        else if (ctrl.shift_bin)
        begin
            digit_next = {adj[DigitWidth-2:0], bit_in};
        end
        else if (ctrl.shift_dig)
        begin
            digit_next = dig_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            digit_reg <= '0;
        end
        else
        begin
            digit_reg <= digit_next;
        end
    end

endmodule

// ----- test/tb_binary_to_decimal_ascii_core.sv -----
module tb_binary_to_decimal_ascii_core;

    timeunit 1ns;
    timeprecision 1ps;

    import b2da_pkg::*;

    // One expected output word: a digit character and the end-of-number flag
    typedef struct {
        logic [CharWidth-1:0] digit_char;
        logic                 last_digit;
    } digit_word_t;

    // Holds the decimal text predicted for every accepted number, in order,
    // and checks each strobed digit word against the oldest one.
    class decimal_text_scoreboard;
        digit_word_t expected_digits[$];
        int          mismatches;
        int          digits_checked;
        int          numbers_noted;

        function new();
            mismatches     = 0;
            digits_checked = 0;
            numbers_noted  = 0;
        endfunction

        function int pending();
            return expected_digits.size();
        endfunction

        task report_mismatch(string what);
            mismatches++;
            $display("%0t ns mismatch: %s", $realtime, what);
        endtask

        // Split the number into decimal digits, least significant first, and
        // queue them in printing order. Zero still gives a single '0'.
        function void note_number(logic [BinWidth-1:0] number);
            logic [BinWidth-1:0]  remaining;
            logic [CharWidth-1:0] chars[$];
            digit_word_t          word;
            remaining = number;
            do
            begin
                chars.push_front(CharZero + CharWidth'(remaining % 10));
                remaining = remaining / 10;
            end
            while (remaining != 0);
            foreach (chars[i])
            begin
                word.digit_char = chars[i];
                word.last_digit = (i == chars.size() - 1);
                expected_digits.push_back(word);
            end
            numbers_noted++;
        endfunction

        task check_digit(logic [CharWidth-1:0] digit_char, logic last_digit);
            digit_word_t want;
            if (expected_digits.size() == 0)
            begin
                report_mismatch($sformatf("unexpected digit word char=%0d last=%b",
                                          digit_char, last_digit));
                return;
            end
            want = expected_digits.pop_front();
            digits_checked++;
            if (digit_char !== want.digit_char)
                report_mismatch($sformatf("digit_char got %0d want %0d",
                                          digit_char, want.digit_char));
            if (last_digit !== want.last_digit)
                report_mismatch($sformatf("last_digit got %b want %b",
                                          last_digit, want.last_digit));
        endtask
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    logic [BinWidth-1:0]  value;
    logic                 strobe;
    logic [CharWidth-1:0] digit_char;
    logic                 last_digit;

    decimal_text_scoreboard text_board;

    // Count how many numbers of each decimal length went through
    int length_seen[1:10];

    binary_to_decimal_ascii_core i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .value      (value),
        .strobe     (strobe),
        .digit_char (digit_char),
        .last_digit (last_digit)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Sample both channels at the edge itself: the block updates with
    // nonblocking assignments, so the values read here are the ones that
    // were on the ports during the cycle that this edge ends.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
                text_board.note_number(value);
            if (strobe)
                text_board.check_digit(digit_char, last_digit);
        end
    end

    function automatic int decimal_length(logic [BinWidth-1:0] number);
        int len;
        len = 1;
        while (number >= 10)
        begin
            number = number / 10;
            len++;
        end
        return len;
    endfunction

    // Offer one number and hold it until the block takes the word. Return
    // at the accepting edge so that the caller may offer the next one at once.
    task automatic send_number(logic [BinWidth-1:0] number);
        start <= 1'b1;
        value <= number;
        do
            @(posedge clk);
        while (busy);
        length_seen[decimal_length(number)]++;
    endtask

    // Drop start for a number of cycles; scramble value meanwhile, since the
    // block must ignore it while start is low.
    task automatic idle_cycles(int cycles);
        if (cycles > 0)
        begin
            start <= 1'b0;
            value <= $urandom;
            repeat (cycles) @(posedge clk);
        end
    endtask

    // Draw a number: mostly a chosen decimal length with random digits, then
    // raw 32-bit patterns, values around powers of ten, and tiny values.
    function automatic logic [BinWidth-1:0] draw_number();
        int     kind;
        int     len;
        longint low;
        longint high;
        longint decade;
        kind = $urandom_range(9, 0);
        if (kind <= 5)
        begin
            len = $urandom_range(10, 1);
            low = 1;
            repeat (len - 1) low = low * 10;
            high = low * 10 - 1;
            if (high > 64'hFFFF_FFFF)
                high = 64'hFFFF_FFFF;
            return $urandom_range(32'(high), 32'(low));
        end
        else if (kind <= 7)
            return $urandom;
        else if (kind == 8)
        begin
            decade = 10;
            repeat ($urandom_range(8, 0)) decade = decade * 10;
            return 32'(decade + longint'($urandom_range(3, 0)) - 2);
        end
        else
            return $urandom_range(20, 0);
    endfunction

    logic [BinWidth-1:0] directed_numbers[$] = '{
        32'd0, 32'd1, 32'd9, 32'd10, 32'd11, 32'd99, 32'd100, 32'd101,
        32'd999, 32'd1000, 32'd99999, 32'd100000, 32'd999999999,
        32'd1000000000, 32'd1000000001, 32'd1234567890, 32'd2147483647,
        32'd2147483648, 32'd3999999999, 32'd4000000000, 32'd4294967294,
        32'd4294967295, 32'hAAAA_AAAA, 32'h5555_5555
    };

    initial
    begin
        int burst;
        int gap;
        int sent_random;

        text_board = new();
        foreach (length_seen[i]) length_seen[i] = 0;
        start = 1'b0;
        value = '0;
        rst_n = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed corners: zero, single digits, several decade boundaries that
        // change the digit count, and the full ten-digit range up to the top.
        foreach (directed_numbers[i])
        begin
            send_number(directed_numbers[i]);
            if ($urandom_range(3, 0) == 0)
                idle_cycles($urandom_range(45, 1));
        end

        // Random part: bursts of back-to-back numbers separated by gaps of
        // random length, so that a new offer lands on every phase of the
        // conversion and the digit output. Some bursts run with no gap.
        sent_random = 0;
        while (sent_random < 420)
        begin
            burst = $urandom_range(8, 1);
            repeat (burst)
            begin
                send_number(draw_number());
                sent_random++;
            end
            gap = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(50, 1);
            idle_cycles(gap);
        end
        idle_cycles(1);

        // Wait for every predicted digit, then watch for stray words for
        // longer than one full conversion takes.
        while (text_board.pending() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);

        $display("covered %0d numbers, %0d digit words checked, %0d mismatches",
                 text_board.numbers_noted, text_board.digits_checked,
                 text_board.mismatches);
        $display("numbers by digit count 1..10: %0d %0d %0d %0d %0d %0d %0d %0d %0d %0d",
                 length_seen[1], length_seen[2], length_seen[3], length_seen[4],
                 length_seen[5], length_seen[6], length_seen[7], length_seen[8],
                 length_seen[9], length_seen[10]);
        if (text_board.mismatches == 0)
            $display("binary_to_decimal_ascii_core regression: pass");
        else
            $display("binary_to_decimal_ascii_core regression: fail");
        $finish;
    end

    // Guard against a hang: the slowest correct run stays far below this.
    initial
    begin
        #5_000_000;
        $display("timeout with %0d digit words outstanding", text_board.pending());
        $display("binary_to_decimal_ascii_core regression: fail");
        $finish;
    end

endmodule
